// ===== sv/assert_macros.svh =====
// Assertion macros shared by the car-following step RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GCF_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define GCF_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/gcf_pkg.sv =====
// Types and constants of the car-following step unit.
// No dependencies; compile first.
package gcf_pkg;

  typedef struct packed {
    logic [19:0] own_position;
    logic [13:0] own_speed;
    logic [13:0] prior_speed;
    logic [19:0] leader_position;
    logic [15:0] step_index;
  } item_t;

  typedef struct packed {
    logic [19:0] next_position;
    logic [13:0] next_speed;
    logic [13:0] next_prior_speed;
  } result_t;

  typedef enum logic [1:0] {
    REG_DESIRED_SPEED  = 2'd0,
    REG_MAX_ACCEL      = 2'd1,
    REG_VEHICLE_LENGTH = 2'd2,
    REG_UPDATE_PERIOD  = 2'd3
  } reg_index_t;

  typedef struct packed {
    reg_index_t  index;
    logic [13:0] value;
  } cfg_t;

  localparam logic [13:0] DESIRED_SPEED_RST  = 14'd5689;
  localparam logic [10:0] MAX_ACCEL_RST      = 11'd435;
  localparam logic [11:0] VEHICLE_LENGTH_RST = 12'd1536;
  localparam logic [7:0]  UPDATE_PERIOD_RST  = 8'd15;

  localparam logic [13:0] SPEED_MAX    = 14'h3FFF;
  localparam logic [19:0] POSITION_MAX = 20'hFFFFF;

  // Braking estimate magnitude is max(BRAKE_FLOOR, a + BRAKE_OFFSET).
  localparam logic [11:0] BRAKE_FLOOR  = 12'd512;
  localparam logic [11:0] BRAKE_OFFSET = 12'd256;

  // floor(t / 5) = (t * RECIP_FIVE) >> 24, exact for t below 2^22.
  localparam logic [21:0] RECIP_FIVE       = 22'd3355444;
  localparam int          RECIP_FIVE_SHIFT = 24;
  // floor(s / 10) = (s * RECIP_TEN) >> 17, exact for s below 2^14.
  localparam logic [13:0] RECIP_TEN        = 14'd13108;
  localparam int          RECIP_TEN_SHIFT  = 17;

endpackage

// ===== sv/gcf_chan.sv =====
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; the payload type comes from gcf_pkg at instantiation.
interface gcf_chan #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/gcf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, NW stages.
// Standalone; used by the top level for all signal-by-signal divisions.
module gcf_div #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
    end

    // shift the next dividend bit into the partial remainder
    always_comb begin
      trial = {rem_in, quo_in[NW-1]};
      diff  = trial - {1'b0, den_in};
      take  = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= take ? diff[DW-1:0] : trial[DW-1:0];
        quo_q[i] <= {quo_in[NW-2:0], take};
        den_q[i] <= den_in;
      end
    end
  end

  assign quo = quo_q[NW-1];
  assign rem = rem_q[NW-1];

endmodule

// ===== sv/gcf_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, NW/2 stages.
// Standalone; used by the top level for both radicands.
module gcf_sqrt #(
  parameter int NW = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NW-1:0]     rad,
  output logic [NW/2-1:0]   root
);

  localparam int RW = NW / 2;

  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [NW-1:0] rad_q  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [NW-1:0] rad_in;
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    // bring down two radicand bits, try 4*root + 1
    always_comb begin
      cur   = {rem_in, rad_in[NW-1:NW-2]};
      trial = {2'b00, root_in, 2'b01};
      diff  = cur - trial;
      take  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= take ? diff[RW+1:0] : cur[RW+1:0];
        root_q[i] <= {root_in[RW-2:0], take};
        rad_q[i]  <= {rad_in[NW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

// ===== sv/gipps_car_following_step_unit.sv =====
// Car-following step unit: top level with config registers and the pipeline.
// Depends on gcf_pkg, gcf_chan, gcf_div, gcf_sqrt and assert_macros.svh.
//
// Usage:
//   item   - input words (follower position, speed, earlier speed, leader
//            position, step index), taken when item.valid and item.ready.
//   result - one word per item (next position, speed, earlier speed), in
//            order, handed over when result.valid and result.ready.
//   cfg    - register writes (index, value); always ready. Write only while
//            no item is in flight.
// Throughput is one word per cycle while result words are taken. The depth
// of the pipeline is set by the free-flow chain: a 52-stage divider, a
// 23-stage root, a multiply and a 38-stage divider in series; the braking
// chain and the period check run beside it and are delayed to meet it.
// Reset clears the valid line and loads the register defaults; the line
// holds no item afterwards. When the receiver holds result.ready low with
// a word waiting, the whole pipeline freezes and item.ready drops in the
// same cycle; nothing is lost or repeated.
`include "assert_macros.svh"

module gipps_car_following_step_unit (
  input  logic     clk,
  input  logic     rst,
  gcf_chan.sink    item,
  gcf_chan.source  result,
  gcf_chan.sink    cfg
);

  // stage numbers, counted in registers after the input register (stage 0)
  localparam int NA     = 52;              // free-flow ratio divider width
  localparam int NSA    = 46;              // free-flow root radicand width
  localparam int NV     = 38;              // correction divider width
  localparam int NB     = 45;              // braking term divider width
  localparam int NSB    = 42;              // braking root radicand width
  localparam int NC     = 16;              // step-index modulo width
  localparam int ST_QA  = NA;
  localparam int ST_RA  = ST_QA + NSA / 2;
  localparam int ST_NUM = ST_RA + 1;
  localparam int ST_QV  = ST_NUM + NV;
  localparam int ST_VA  = ST_QV + 1;
  localparam int ST_SPD = ST_VA + 1;
  localparam int ST_OUT = ST_SPD + 1;
  localparam int ST_W   = 2;
  localparam int ST_QB  = ST_W + NB;
  localparam int ST_R   = ST_QB + 1;
  localparam int ST_RB  = ST_R + NSB / 2;
  localparam int ST_VB  = ST_RB + 1;
  localparam int ST_QC  = NC;
  localparam int ST_UPD = ST_QC + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [13:0] desired_speed;
  logic [10:0] max_accel;
  logic [11:0] vehicle_length;
  logic [7:0]  update_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      desired_speed  <= gcf_pkg::DESIRED_SPEED_RST;
      max_accel      <= gcf_pkg::MAX_ACCEL_RST;
      vehicle_length <= gcf_pkg::VEHICLE_LENGTH_RST;
      update_period  <= gcf_pkg::UPDATE_PERIOD_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.index)
        gcf_pkg::REG_DESIRED_SPEED:  desired_speed  <= cfg.data.value;
        gcf_pkg::REG_MAX_ACCEL:      max_accel      <= cfg.data.value[10:0];
        gcf_pkg::REG_VEHICLE_LENGTH: vehicle_length <= cfg.data.value[11:0];
        gcf_pkg::REG_UPDATE_PERIOD:  update_period  <= cfg.data.value[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // Values derived from the registers; a zero period or desired speed acts as one.
  logic [7:0]  p_eff;
  logic [13:0] vd_eff;
  logic [19:0] vd40;
  logic [16:0] a50;
  logic [17:0] a100;
  logic [13:0] a5;
  logic [11:0] e_sum;
  logic [11:0] brake;
  logic [18:0] ap_q;

  always_comb begin
    p_eff  = (update_period == 8'd0) ? 8'd1 : update_period;
    vd_eff = (desired_speed == 14'd0) ? 14'd1 : desired_speed;
    vd40   = 20'(vd_eff) * 20'd40;
    a50    = 17'(max_accel) * 17'd50;
    a100   = 18'(max_accel) * 18'd100;
    a5     = 14'(max_accel) * 14'd5;
    e_sum  = 12'(max_accel) + gcf_pkg::BRAKE_OFFSET;
    brake  = (e_sum > gcf_pkg::BRAKE_FLOOR) ? e_sum : gcf_pkg::BRAKE_FLOOR;
  end

  // a * P, registered so that products built on it start from a flop
  always_ff @(posedge clk) begin
    ap_q <= 19'(max_accel) * 19'(p_eff);
  end

  // ---------------------------------------------------------------------
  // Pipeline control: one global advance, valid bits ride along
  // ---------------------------------------------------------------------
  logic [ST_OUT:0] vld;
  logic            en;

  assign en         = !vld[ST_OUT] || result.ready;
  assign item.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST_OUT-1:0], item.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Input register and delay lines (index = stage number unless noted)
  // ---------------------------------------------------------------------
  logic        [19:0] x_ln  [ST_SPD+1];
  logic        [13:0] v_ln  [ST_VA+1];
  logic        [13:0] u_ln  [ST_VA+1];
  logic        [15:0] k0;
  logic signed [21:0] d0;

  always_ff @(posedge clk) begin
    if (en) begin
      x_ln[0] <= item.data.own_position;
      v_ln[0] <= item.data.own_speed;
      u_ln[0] <= item.data.prior_speed;
      k0      <= item.data.step_index;
      // gap to the leader minus the vehicle length, signed
      d0      <= $signed({2'b00, item.data.leader_position})
               - $signed({10'd0, vehicle_length})
               - $signed({2'b00, item.data.own_position});
      for (int i = 1; i <= ST_SPD; i++) x_ln[i] <= x_ln[i-1];
      for (int i = 1; i <= ST_VA; i++) begin
        v_ln[i] <= v_ln[i-1];
        u_ln[i] <= u_ln[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Update-step check: k mod P == 0
  // ---------------------------------------------------------------------
  logic [NC-1:0] quo_c;
  logic [7:0]    rem_c;
  logic          upd_ln [ST_VA-ST_UPD+1];   // index j is stage ST_UPD + j

  gcf_div #(.NW(NC), .DW(8)) u_div_mod (
    .clk (clk), .en (en), .num (k0), .den (p_eff), .quo (quo_c), .rem (rem_c)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      upd_ln[0] <= (rem_c == 8'd0);
      for (int i = 1; i <= ST_VA - ST_UPD; i++) upd_ln[i] <= upd_ln[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Free-flow speed: v +/- a*P*|V-v|*sqrt(s) / (V * 2^18)
  // ---------------------------------------------------------------------
  logic [13:0]    diff0;
  logic [32:0]    t1_ln [ST_RA];           // index j is stage j + 1
  logic [NA-1:0]  num_a;
  logic [NA-1:0]  quo_a;
  logic [19:0]    rem_a;
  logic [NSA/2-1:0] root_a;
  logic [55:0]    num_v;
  logic [NV-1:0]  quo_v;
  logic [13:0]    rem_v;
  logic           low_ln [ST_QV-ST_NUM];   // index j is stage ST_NUM + 1 + j
  logic           ge_v;
  logic [39:0]    v_ext;
  logic [39:0]    q_ext;
  logic           q_cor;
  logic signed [39:0] va_q;

  always_comb begin
    diff0 = (vd_eff >= v_ln[0]) ? (vd_eff - v_ln[0]) : (v_ln[0] - vd_eff);
    num_a = {20'(vd_eff) + 20'(v_ln[0]) * 20'd40, 32'd0};
  end

  gcf_div #(.NW(NA), .DW(20)) u_div_ratio (
    .clk (clk), .en (en), .num (num_a), .den (vd40), .quo (quo_a), .rem (rem_a)
  );

  // the ratio stays below 2^46; drop the upper quotient bits
  gcf_sqrt #(.NW(NSA)) u_sqrt_free (
    .clk (clk), .en (en), .rad (quo_a[NSA-1:0]), .root (root_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      t1_ln[0] <= 33'(ap_q) * 33'(diff0);
      for (int i = 1; i < ST_RA; i++) t1_ln[i] <= t1_ln[i-1];
      num_v <= 56'(t1_ln[ST_RA-1]) * 56'(root_a);
      low_ln[0] <= |num_v[17:0];
      for (int i = 1; i < ST_QV - ST_NUM; i++) low_ln[i] <= low_ln[i-1];
    end
  end

  gcf_div #(.NW(NV), .DW(14)) u_div_corr (
    .clk (clk), .en (en), .num (num_v[55:18]), .den (vd_eff), .quo (quo_v), .rem (rem_v)
  );

  // above the desired speed the correction is rounded toward minus infinity
  always_comb begin
    ge_v  = (vd_eff >= v_ln[ST_QV]);
    v_ext = {26'd0, v_ln[ST_QV]};
    q_ext = {2'b00, quo_v};
    q_cor = (rem_v != 14'd0) || low_ln[ST_QV-ST_NUM-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va_q <= ge_v ? $signed(v_ext + q_ext) : $signed(v_ext - q_ext - 40'(q_cor));
    end
  end

  // ---------------------------------------------------------------------
  // Safe-braking speed: floor((sqrt(max(0, M + floor(50 a u^2 / e))) - aP) / 5)
  // with M = a^2 P^2 + 100 a D - 5 a v
  // ---------------------------------------------------------------------
  logic        [27:0] usq1;
  logic signed [40:0] ad1;
  logic        [27:0] av1;
  logic        [37:0] a2p2_1;
  logic        [44:0] w2;
  logic signed [41:0] m_ln [ST_QB-ST_W+1];  // index j is stage ST_W + j
  logic        [NB-1:0] quo_b;
  logic        [11:0]   rem_b;
  logic signed [46:0]   r_sum;
  logic        [NSB-1:0] r_q;
  logic        [NSB/2-1:0] root_b;
  logic signed [21:0]   tb;
  logic        [42:0]   tb_prod;
  logic        [18:0]   vb_ln [ST_VA-ST_VB+1]; // index j is stage ST_VB + j

  always_ff @(posedge clk) begin
    if (en) begin
      usq1   <= 28'(u_ln[0]) * 28'(u_ln[0]);
      ad1    <= 41'($signed({1'b0, a100})) * 41'(d0);
      av1    <= 28'(a5) * 28'(v_ln[0]);
      a2p2_1 <= 38'(ap_q) * 38'(ap_q);
      w2     <= 45'(a50) * 45'(usq1);
      m_ln[0] <= $signed({4'd0, a2p2_1}) + 42'(ad1) - $signed({14'd0, av1});
      for (int i = 1; i <= ST_QB - ST_W; i++) m_ln[i] <= m_ln[i-1];
    end
  end

  gcf_div #(.NW(NB), .DW(12)) u_div_brake (
    .clk (clk), .en (en), .num (w2), .den (brake), .quo (quo_b), .rem (rem_b)
  );

  // clamp a negative radicand to zero
  assign r_sum = 47'(m_ln[ST_QB-ST_W]) + $signed({2'b00, quo_b});

  always_ff @(posedge clk) begin
    if (en) begin
      r_q <= (r_sum < 0) ? '0 : r_sum[NSB-1:0];
    end
  end

  gcf_sqrt #(.NW(NSB)) u_sqrt_brake (
    .clk (clk), .en (en), .rad (r_q), .root (root_b)
  );

  always_comb begin
    tb      = $signed({1'b0, root_b}) - $signed({3'b000, ap_q});
    tb_prod = 43'(tb[20:0]) * 43'(gcf_pkg::RECIP_FIVE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vb_ln[0] <= (tb < 0) ? 19'd0 : tb_prod[gcf_pkg::RECIP_FIVE_SHIFT +: 19];
      for (int i = 1; i <= ST_VA - ST_VB; i++) vb_ln[i] <= vb_ln[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Merge: lower of the two speeds, clamp, keep the old speed off update steps, then advance the position
  // ---------------------------------------------------------------------
  logic signed [39:0] vb_ext;
  logic signed [39:0] m_sel;
  logic        [13:0] spd_new;
  logic        [13:0] spd_q;
  logic        [13:0] prior_q;
  logic        [27:0] step_prod;
  logic        [20:0] pos_sum;
  logic        [19:0] pos_out;
  logic        [13:0] spd_out;
  logic        [13:0] prior_out;

  always_comb begin
    vb_ext = $signed({21'd0, vb_ln[ST_VA-ST_VB]});
    m_sel  = (va_q < vb_ext) ? va_q : vb_ext;
    if (m_sel < 0) begin
      spd_new = 14'd0;
    end else if (m_sel > $signed({26'd0, gcf_pkg::SPEED_MAX})) begin
      spd_new = gcf_pkg::SPEED_MAX;
    end else begin
      spd_new = m_sel[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spd_q   <= upd_ln[ST_VA-ST_UPD] ? spd_new : v_ln[ST_VA];
      prior_q <= upd_ln[ST_VA-ST_UPD] ? v_ln[ST_VA] : u_ln[ST_VA];
    end
  end

  // position moves by speed / 10 per step, saturating at the top
  always_comb begin
    step_prod = 28'(spd_q) * 28'(gcf_pkg::RECIP_TEN);
    pos_sum   = {1'b0, x_ln[ST_SPD]} + 21'(step_prod[27:gcf_pkg::RECIP_TEN_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_out   <= pos_sum[20] ? gcf_pkg::POSITION_MAX : pos_sum[19:0];
      spd_out   <= spd_q;
      prior_out <= prior_q;
    end
  end

  assign result.valid                 = vld[ST_OUT];
  assign result.data.next_position    = pos_out;
  assign result.data.next_speed       = spd_out;
  assign result.data.next_prior_speed = prior_out;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a held result word freezes every stage of the line
  `GCF_ASSERT_NXT(a_stall_freezes_line, vld[ST_OUT] && !result.ready, $stable(vld))
  // with a period of one every step is an update step
  `GCF_ASSERT_IMP(a_unit_period_updates, vld[ST_UPD] && update_period <= 8'd1, upd_ln[0])
  // below the desired speed the free-flow speed never falls
  `GCF_ASSERT_IMP(a_free_flow_rises, vld[ST_VA] && vd_eff >= v_ln[ST_VA], va_q >= $signed({26'd0, v_ln[ST_VA]}))

endmodule

// ===== dv/gipps_car_following_step_unit_tb.sv =====
// Testbench for the car-following step unit: drives follower/leader words,
// predicts each result with an integer model of the Gipps step, and checks.
// Depends on gcf_pkg, gcf_chan and the unit's RTL.
`timescale 1ns / 1ps

module gipps_car_following_step_unit_tb;

  localparam int LATENCY = 117;

  logic clk;
  logic rst;

  gcf_chan #(.payload_t(gcf_pkg::item_t))   item_ch ();
  gcf_chan #(.payload_t(gcf_pkg::result_t)) result_ch ();
  gcf_chan #(.payload_t(gcf_pkg::cfg_t))    cfg_ch ();

  gipps_car_following_step_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source),
    .cfg    (cfg_ch.sink)
  );

  // Register copies held by the predictor.
  logic [13:0] set_speed;
  logic [10:0] set_accel;
  logic [11:0] set_length;
  logic [7:0]  set_period;

  gcf_pkg::item_t   pending_words[$];
  gcf_pkg::result_t expected_steps[$];
  int      mismatch_count = 0;
  bit      hold_result;   // long receiver hold-off requested
  int      hold_cycles;
  bit      word_taken;    // input word accepted at the last rising edge
  bit      result_taken;  // result word accepted at the last rising edge

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // Integer square root, floor.
  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Gipps step: free-flow speed vs safe-braking speed on update steps.
  function automatic gcf_pkg::result_t gipps_step(input gcf_pkg::item_t w);
    gcf_pkg::result_t o;
    longint unsigned p, vd, v, u, a, s, sq, diff, num, den, q, pos, spd, prior;
    longint signed va, vb, e, d, n, t, m;
    p = (set_period == 8'd0) ? 64'd1 : 64'(set_period);
    vd = (set_speed == 14'd0) ? 64'd1 : 64'(set_speed);
    v = 64'(w.own_speed);
    u = 64'(w.prior_speed);
    a = 64'(set_accel);
    spd = v;
    prior = u;
    if (64'(w.step_index) % p == 64'd0) begin
      s = ((vd + 40 * v) << 32) / (40 * vd);
      sq = isqrt(s);
      diff = (vd >= v) ? vd - v : v - vd;
      num = a * p * diff * sq;
      den = vd << 18;
      q = num / den;
      if (vd >= v) va = longint'(v) + longint'(q);
      else begin
        if (q * den != num) q++;
        va = longint'(v) - longint'(q);
      end
      e = (a + 256 > 512) ? longint'(a + 256) : 64'sd512;
      d = longint'(w.leader_position) - longint'(set_length) - longint'(w.own_position);
      n = 10 * e * longint'(a * a * p * p) + 1000 * longint'(a) * e * d
        - 50 * longint'(a) * e * longint'(v) + 500 * longint'(a) * longint'(u * u);
      if (n < 0) n = 0;
      t = longint'(isqrt(longint'(n) / (10 * e))) - longint'(a * p);
      vb = (t < 0) ? 0 : t / 5;
      m = (va < vb) ? va : vb;
      if (m < 0) m = 0;
      if (m > longint'(gcf_pkg::SPEED_MAX)) m = longint'(gcf_pkg::SPEED_MAX);
      prior = v;
      spd = m;
    end
    pos = 64'(w.own_position) + spd / 10;
    if (pos > 64'(gcf_pkg::POSITION_MAX)) pos = 64'(gcf_pkg::POSITION_MAX);
    o.next_position = pos[19:0];
    o.next_speed = spd[13:0];
    o.next_prior_speed = prior[13:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Append a word to the pending queue.
  task automatic queue_word(input gcf_pkg::item_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  // Input side: note each word taken at the rising edge and predict its result.
  always @(posedge clk) begin
    word_taken = !rst && item_ch.valid && item_ch.ready;
    if (word_taken) begin
      expected_steps.insert(expected_steps.size(), gipps_step(item_ch.data));
      void'(pending_words.pop_front());
    end
  end

  // Driver: offer queued words with random gaps.
  int send_gap;
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (word_taken)
        send_gap = (hold_result || $urandom_range(2) == 0) ? 0 : $urandom_range(12);
      if (send_gap > 0) begin
        send_gap--;
        item_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        item_ch.valid <= 1'b1;
        item_ch.data <= pending_words[0];
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: sample at the rising edge, compare with the oldest expectation.
  always @(posedge clk) begin
    gcf_pkg::result_t want;
    result_taken = !rst && result_ch.valid && result_ch.ready;
    if (result_taken) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected word", longint'(result_ch.data), 0);
      end else begin
        want = expected_steps.pop_front();
        if (result_ch.data.next_position !== want.next_position)
          report_mismatch("next_position", result_ch.data.next_position, want.next_position);
        if (result_ch.data.next_speed !== want.next_speed)
          report_mismatch("next_speed", result_ch.data.next_speed, want.next_speed);
        if (result_ch.data.next_prior_speed !== want.next_prior_speed)
          report_mismatch("next_prior_speed", result_ch.data.next_prior_speed,
                          want.next_prior_speed);
      end
    end
  end

  // Receiver: random stalls per word, or a long hold-off when asked.
  int recv_gap;
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_gap = 0;
      hold_cycles = 0;
    end else if (hold_result) begin
      result_ch.ready <= 1'b0;
      hold_cycles++;
    end else begin
      if (result_taken)
        recv_gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
      if (recv_gap > 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input gcf_pkg::reg_index_t idx, input logic [13:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, value: value};
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      gcf_pkg::REG_DESIRED_SPEED:  set_speed  = value;
      gcf_pkg::REG_MAX_ACCEL:      set_accel  = value[10:0];
      gcf_pkg::REG_VEHICLE_LENGTH: set_length = value[11:0];
      gcf_pkg::REG_UPDATE_PERIOD:  set_period = value[7:0];
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every expected word is back, then let the pipe drain.
  task automatic drain();
    while (pending_words.size() > 0 || expected_steps.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic gcf_pkg::item_t random_word(input bit near);
    gcf_pkg::item_t w;
    w.own_position = 20'($urandom_range(20'hFFFFF));
    w.own_speed = 14'($urandom_range(gcf_pkg::SPEED_MAX));
    w.prior_speed = 14'($urandom_range(gcf_pkg::SPEED_MAX));
    w.step_index = 16'($urandom_range(16'hFFFF));
    // Mostly realistic gaps so the braking term is neither clamped nor huge.
    if (near) begin
      w.own_speed = 14'($urandom_range(8000));
      w.prior_speed = 14'($urandom_range(8000));
      w.own_position = 20'($urandom_range(20'hF0000));
      w.leader_position = w.own_position + 20'($urandom_range(20000));
      if ($urandom_range(1) != 0) w.step_index = 16'(set_period * $urandom_range(200));
    end else begin
      w.leader_position = 20'($urandom_range(20'hFFFFF));
    end
    return w;
  endfunction

  task automatic run_phase(input int count);
    for (int i = 0; i < count; i++) queue_word(random_word($urandom_range(3) != 0));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    hold_result = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '{index: gcf_pkg::REG_DESIRED_SPEED, value: 14'd0};
    set_speed = gcf_pkg::DESIRED_SPEED_RST;
    set_accel = gcf_pkg::MAX_ACCEL_RST;
    set_length = gcf_pkg::VEHICLE_LENGTH_RST;
    set_period = gcf_pkg::UPDATE_PERIOD_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, update and hold steps, leader behind,
    // speed above desired, saturating position.
    queue_word('{20'd0, 14'd0, 14'd0, 20'd0, 16'd0});
    queue_word('{20'hFFFFF, gcf_pkg::SPEED_MAX, gcf_pkg::SPEED_MAX, 20'hFFFFF, 16'hFFFF});
    queue_word('{20'hFFFFF, gcf_pkg::SPEED_MAX, gcf_pkg::SPEED_MAX, 20'hFFFFF, 16'd0});
    queue_word('{20'hFFFFF, 14'd5000, 14'd0, 20'hFFFFF, 16'd1});
    queue_word('{20'd50000, 14'd3000, 14'd2900, 20'd10, 16'd0});
    queue_word('{20'd1000, 14'd9000, 14'd9000, 20'd200000, 16'd30});
    queue_word('{20'd1000, 14'd1000, 14'd1000, 20'd20000, 16'd15});
    queue_word('{20'd0, 14'd0, gcf_pkg::SPEED_MAX, 20'hFFFFF, 16'd45});
    queue_word('{20'hAAAAA, 14'h2AAA, 14'h1555, 20'h55555, 16'hAAAA});
    queue_word('{20'h55555, 14'h1555, 14'h2AAA, 20'hAAAAA, 16'h5555});
    drain();

    // Extreme settings: period 0, 1 and 255, desired speed 0, 1 and max, max and min accel/length.
    write_reg(gcf_pkg::REG_UPDATE_PERIOD, 14'd0);
    write_reg(gcf_pkg::REG_DESIRED_SPEED, 14'd0);
    queue_word('{20'd100, 14'd500, 14'd400, 20'd9000, 16'd7});
    queue_word('{20'd100, 14'd0, 14'd0, 20'd100, 16'd3});
    drain();
    write_reg(gcf_pkg::REG_DESIRED_SPEED, gcf_pkg::SPEED_MAX);
    write_reg(gcf_pkg::REG_MAX_ACCEL, 14'd2047);
    write_reg(gcf_pkg::REG_VEHICLE_LENGTH, 14'd4095);
    write_reg(gcf_pkg::REG_UPDATE_PERIOD, 14'd255);
    run_phase(200);
    write_reg(gcf_pkg::REG_DESIRED_SPEED, 14'd1);
    write_reg(gcf_pkg::REG_MAX_ACCEL, 14'd1);
    write_reg(gcf_pkg::REG_VEHICLE_LENGTH, 14'd0);
    write_reg(gcf_pkg::REG_UPDATE_PERIOD, 14'd1);
    run_phase(200);

    // Long receiver hold-off while words keep coming: fill and stall.
    write_reg(gcf_pkg::REG_DESIRED_SPEED, gcf_pkg::DESIRED_SPEED_RST);
    write_reg(gcf_pkg::REG_MAX_ACCEL, 14'(gcf_pkg::MAX_ACCEL_RST));
    write_reg(gcf_pkg::REG_VEHICLE_LENGTH, 14'(gcf_pkg::VEHICLE_LENGTH_RST));
    write_reg(gcf_pkg::REG_UPDATE_PERIOD, 14'd2);
    for (int i = 0; i < 300; i++) queue_word(random_word(1));
    hold_result = 1;
    wait (hold_cycles >= 400);
    hold_result = 0;
    drain();

    // Random settings, random content.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(gcf_pkg::REG_DESIRED_SPEED, 14'($urandom_range(1, gcf_pkg::SPEED_MAX)));
      write_reg(gcf_pkg::REG_MAX_ACCEL, 14'($urandom_range(1, 2047)));
      write_reg(gcf_pkg::REG_VEHICLE_LENGTH, 14'($urandom_range(4095)));
      write_reg(gcf_pkg::REG_UPDATE_PERIOD,
                14'(ph[0] ? $urandom_range(1, 4) : $urandom_range(1, 255)));
      run_phase(200);
    end

    if (mismatch_count == 0 && expected_steps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
